// ===== hdl/mlrd_pkg.sv =====
// mlrd_pkg: shared types and constants of the multi-level run detector
// used by the level cells and the top level; no dependencies

package mlrd_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_LEVEL   = 2'd0;
	localparam logic [1:0] CFG_LEVEL_COUNT = 2'd1;
	localparam logic [1:0] CFG_VALLEY_MODE = 2'd2;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned LEVEL_W     = 16;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned OUT_IDX_W   = 4;
	localparam int unsigned OUT_POS_W   = 32;
	localparam int unsigned FRAC_BITS   = 8;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic load;       // an item is accepted this cycle
		logic shift;      // report chain moves one cell toward cell 0
		logic last_item;  // accepted item ends the track
		logic valley;     // compare direction
	} cell_ctl_t;

endpackage

// ===== hdl/mlrd_if.sv =====
// mlrd_in_if / mlrd_out_if: valid/ready channels of the run detector
// payload widths come from mlrd_pkg

interface mlrd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [mlrd_pkg::SAMPLE_W-1:0]    sample;
	logic                                    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mlrd_out_if;
	logic                               valid;
	logic                               ready;
	logic [mlrd_pkg::OUT_IDX_W-1:0]     level_index;
	logic [mlrd_pkg::OUT_POS_W-1:0]     run_start;
	logic [mlrd_pkg::OUT_POS_W-1:0]     run_end;
	logic                               last_of_batch;

	modport source (output valid, output level_index, output run_start, output run_end,
		output last_of_batch, input ready);
	modport sink   (input valid, input level_index, input run_start, input run_end,
		input last_of_batch, output ready);
endinterface

// ===== hdl/mlrd_cell.sv =====
// mlrd_cell: one threshold level; holds the open run start and one report slot
// the report slots of all cells form a shift chain toward cell 0; uses mlrd_pkg

module mlrd_cell #(
	parameter int CELL_IDX      = 0,
	parameter int IDX_W         = 4,
	parameter int POSITION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mlrd_pkg::cell_ctl_t                   ctl,
	input  logic signed [mlrd_pkg::LEVEL_W-1:0]   min_level,
	input  logic [mlrd_pkg::COUNT_W-1:0]          level_count,
	input  logic signed [mlrd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [POSITION_BITS-1:0]              pos,
	input  logic [POSITION_BITS-1:0]              pos_m1,
	input  logic                                  nxt_valid,
	input  logic [IDX_W-1:0]                      nxt_idx,
	input  logic [POSITION_BITS-1:0]              nxt_start,
	input  logic [POSITION_BITS-1:0]              nxt_end,
	output logic                                  slot_valid,
	output logic [IDX_W-1:0]                      slot_idx,
	output logic [POSITION_BITS-1:0]              slot_start,
	output logic [POSITION_BITS-1:0]              slot_end
);

	localparam logic [6:0]       IDX7    = 7'(CELL_IDX);
	localparam logic [16:0]      IDX17   = 17'(CELL_IDX);
	localparam logic [IDX_W-1:0] IDX_OWN = IDX_W'(CELL_IDX);

	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] start_nxt;
	logic [POSITION_BITS-1:0] run_end;
	logic                     slot_valid_q;
	logic [IDX_W-1:0]         slot_idx_q;
	logic [POSITION_BITS-1:0] slot_start_q;
	logic [POSITION_BITS-1:0] slot_end_q;
	logic signed [16:0]       thr_int;
	logic signed [31:0]       thr;
	logic                     active;
	logic                     in_band;
	logic                     run_open;
	logic                     closing;

	always_comb begin
		thr_int  = $signed({min_level[15], min_level}) + $signed(IDX17);
		thr      = $signed({{7{thr_int[16]}}, thr_int, {mlrd_pkg::FRAC_BITS{1'b0}}});
		// level zero is always in use; a count above the cell range covers every cell
		active   = (CELL_IDX == 0) || (IDX7 < {2'b00, level_count});
		in_band  = ctl.valley ? (sample <= thr) : (sample >= thr);
		run_open = (start_q != '0);
		closing  = active && !in_band && run_open;
		// several samples can share a saturated position
		run_end  = (pos_m1 < start_q) ? start_q : pos_m1;

		if (!active || !in_band) begin
			start_nxt = '0;
		end else if (run_open) begin
			start_nxt = start_q;
		end else begin
			start_nxt = pos;
		end
		if (ctl.last_item) begin
			start_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			slot_valid_q <= 1'b0;
		end else if (ctl.load) begin
			start_q      <= start_nxt;
			slot_valid_q <= closing;
		end else if (ctl.shift) begin
			slot_valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_idx_q   <= IDX_OWN;
			slot_start_q <= start_q;
			slot_end_q   <= run_end;
		end else if (ctl.shift) begin
			slot_idx_q   <= nxt_idx;
			slot_start_q <= nxt_start;
			slot_end_q   <= nxt_end;
		end
	end

	assign slot_valid = slot_valid_q;
	assign slot_idx   = slot_idx_q;
	assign slot_start = slot_start_q;
	assign slot_end   = slot_end_q;

endmodule

// ===== hdl/multi_level_run_detector.sv =====
// multi_level_run_detector: top level, a row of level cells with a report shift chain
// depends on mlrd_pkg, mlrd_in_if / mlrd_out_if and mlrd_cell
//
// channel   dir  handshake      payload
// samples   in   valid/ready    sample[31:0] signed, last_sample
// runs      out  valid/ready    level_index[3:0], run_start[31:0], run_end[31:0], last_of_batch
// cfg       in   cfg_we         cfg_index[1:0], cfg_data[15:0]
//
// an item that closes no run leaves the chain empty; samples are taken every cycle in that case
// an item that closes runs fills the report chain, which drains one cell per cycle unless the output
// stalls; the next item waits until the highest level that closed has drained out of the chain
// output stalls freeze the chain; a held result sits in the output register
// asynchronous reset: no runs open, position one, registers min 0, 16 levels, peak mode

module multi_level_run_detector #(
	parameter int MAX_LEVELS    = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mlrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mlrd_pkg::CFG_DATA_W-1:0]      cfg_data,
	mlrd_in_if.sink                              samples,
	mlrd_out_if.source                           runs
);

	localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	logic signed [mlrd_pkg::LEVEL_W-1:0] min_level_q;
	logic [mlrd_pkg::COUNT_W-1:0]        level_count_q;
	logic                                valley_mode_q;
	logic [POSITION_BITS-1:0]            pos_q;
	logic [POSITION_BITS-1:0]            pos_m1;

	logic [MAX_LEVELS-1:0]               slot_valid;
	logic [IDX_W-1:0]                    slot_idx   [MAX_LEVELS];
	logic [POSITION_BITS-1:0]            slot_start [MAX_LEVELS];
	logic [POSITION_BITS-1:0]            slot_end   [MAX_LEVELS];

	logic                                out_valid_q;
	logic [mlrd_pkg::OUT_IDX_W-1:0]      out_idx_q;
	logic [mlrd_pkg::OUT_POS_W-1:0]      out_start_q;
	logic [mlrd_pkg::OUT_POS_W-1:0]      out_end_q;
	logic                                out_last_q;

	logic                                any_pending;
	logic                                advance;
	logic                                accept;
	mlrd_pkg::cell_ctl_t                 ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q   <= '0;
			level_count_q <= mlrd_pkg::COUNT_W'(16);
			valley_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlrd_pkg::CFG_MIN_LEVEL:   min_level_q   <= $signed(cfg_data);
				mlrd_pkg::CFG_LEVEL_COUNT: level_count_q <= cfg_data[mlrd_pkg::COUNT_W-1:0];
				mlrd_pkg::CFG_VALLEY_MODE: valley_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign any_pending   = |slot_valid;
	assign advance       = !out_valid_q || runs.ready;
	assign samples.ready = !any_pending;
	assign accept        = samples.valid && !any_pending;
	assign pos_m1        = pos_q - POSITION_BITS'(1);

	always_comb begin
		ctl.load      = accept;
		ctl.shift     = advance && any_pending;
		ctl.last_item = samples.last_sample;
		ctl.valley    = valley_mode_q;
	end

	// 1-based position, saturating at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POSITION_BITS'(1);
		end else if (accept) begin
			if (samples.last_sample) begin
				pos_q <= POSITION_BITS'(1);
			end else if (pos_q != '1) begin
				pos_q <= pos_q + POSITION_BITS'(1);
			end
		end
	end

	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
		logic                     nv;
		logic [IDX_W-1:0]         ni;
		logic [POSITION_BITS-1:0] ns;
		logic [POSITION_BITS-1:0] ne;

		if (g == MAX_LEVELS - 1) begin : g_top
			assign nv = 1'b0;
			assign ni = '0;
			assign ns = '0;
			assign ne = '0;
		end else begin : g_mid
			assign nv = slot_valid[g+1];
			assign ni = slot_idx[g+1];
			assign ns = slot_start[g+1];
			assign ne = slot_end[g+1];
		end

		mlrd_cell #(
			.CELL_IDX      (g),
			.IDX_W         (IDX_W),
			.POSITION_BITS (POSITION_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.min_level   (min_level_q),
			.level_count (level_count_q),
			.sample      (samples.sample),
			.pos         (pos_q),
			.pos_m1      (pos_m1),
			.nxt_valid   (nv),
			.nxt_idx     (ni),
			.nxt_start   (ns),
			.nxt_end     (ne),
			.slot_valid  (slot_valid[g]),
			.slot_idx    (slot_idx[g]),
			.slot_start  (slot_start[g]),
			.slot_end    (slot_end[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= slot_valid[0];
		end
	end

	// cell 0 feeds the output register; it is the item's last report when no valid slot sits above it
	always_ff @(posedge clk) begin
		if (advance) begin
			out_idx_q   <= mlrd_pkg::OUT_IDX_W'(slot_idx[0]);
			out_start_q <= mlrd_pkg::OUT_POS_W'(slot_start[0]);
			out_end_q   <= mlrd_pkg::OUT_POS_W'(slot_end[0]);
			out_last_q  <= ((slot_valid >> 1) == '0);
		end
	end

	assign runs.valid         = out_valid_q;
	assign runs.level_index   = out_idx_q;
	assign runs.run_start     = out_start_q;
	assign runs.run_end       = out_end_q;
	assign runs.last_of_batch = out_last_q;

endmodule

// ===== tb/multi_level_run_detector_checker.sv =====
// multi_level_run_detector_checker: watches the sample, run and register ports of the
// run detector, predicts every run report and compares it with what comes out
// depends on mlrd_pkg and mlrd_in_if / mlrd_out_if

module multi_level_run_detector_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mlrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mlrd_pkg::CFG_DATA_W-1:0]      cfg_data,
	mlrd_in_if                                   sample_ch,
	mlrd_out_if                                  run_ch,
	output int unsigned                          outstanding,
	output int unsigned                          mismatches
);
	import mlrd_pkg::*;

	localparam int LEVELS = 16;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] level_index;
		logic [OUT_POS_W-1:0] run_start;
		logic [OUT_POS_W-1:0] run_end;
		logic                 last_of_batch;
	} run_report_t;

	logic signed [LEVEL_W-1:0] min_level;
	logic [COUNT_W-1:0]        level_count;
	logic                      valley;
	logic [OUT_POS_W-1:0]      run_origin [LEVELS];
	logic [OUT_POS_W-1:0]      position;
	run_report_t               closed_runs_due [$];
	run_report_t               want;
	run_report_t               got;

	// updates the open runs for one sample and queues the runs it closes
	task automatic track_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
		int          active;
		longint      threshold;
		logic        hit;
		logic        have_rep;
		run_report_t rep;
		have_rep = 1'b0;
		rep = '0;
		active = (level_count == 0) ? 1 : (level_count > LEVELS) ? LEVELS : int'(level_count);
		for (int i = 0; i < LEVELS; i++) begin
			if (i >= active) begin
				run_origin[i] = '0;
			end else begin
				threshold = (longint'(min_level) + i) * 256;
				hit = valley ? (longint'(value) <= threshold) : (longint'(value) >= threshold);
				if (hit) begin
					if (run_origin[i] == '0)
						run_origin[i] = position;
				end else if (run_origin[i] != '0) begin
					// hold back one report so the last one can be flagged
					if (have_rep)
						closed_runs_due.insert(closed_runs_due.size(), rep);
					rep.level_index = OUT_IDX_W'(i);
					rep.run_start = run_origin[i];
					rep.run_end = (position - 1 < run_origin[i]) ? run_origin[i] : position - 1;
					rep.last_of_batch = 1'b0;
					have_rep = 1'b1;
					run_origin[i] = '0;
				end
			end
		end
		if (have_rep) begin
			rep.last_of_batch = 1'b1;
			closed_runs_due.insert(closed_runs_due.size(), rep);
		end
		if (last) begin
			for (int i = 0; i < LEVELS; i++)
				run_origin[i] = '0;
			position = 1;
		end else if (position != '1) begin
			position = position + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level = '0;
			level_count = COUNT_W'(16);
			valley = 1'b0;
			for (int i = 0; i < LEVELS; i++)
				run_origin[i] = '0;
			position = 1;
			closed_runs_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_LEVEL:   min_level = cfg_data[LEVEL_W-1:0];
					CFG_LEVEL_COUNT: level_count = cfg_data[COUNT_W-1:0];
					CFG_VALLEY_MODE: valley = cfg_data[0];
					default: ;
				endcase
			end
			if (run_ch.valid && run_ch.ready) begin
				got = '{run_ch.level_index, run_ch.run_start, run_ch.run_end,
					run_ch.last_of_batch};
				if (closed_runs_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected report: level %0d start %0d end %0d last %0b",
						$time, got.level_index, got.run_start, got.run_end,
						got.last_of_batch);
				end else begin
					want = closed_runs_due.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected lvl %0d %0d-%0d last %0b, got lvl %0d %0d-%0d last %0b",
							$time, want.level_index, want.run_start, want.run_end,
							want.last_of_batch, got.level_index, got.run_start, got.run_end,
							got.last_of_batch);
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				track_sample(sample_ch.sample, sample_ch.last_sample);
		end
		outstanding = closed_runs_due.size();
	end

endmodule

// ===== tb/multi_level_run_detector_test.sv =====
// multi_level_run_detector_test: top of the run detector bench; drives samples, register
// writes and output stalls, and prints the verdict
// depends on mlrd_pkg, mlrd_in_if / mlrd_out_if, the block and multi_level_run_detector_checker

module multi_level_run_detector_test;
	import mlrd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int          HOLD_CYCLES  = 300;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int unsigned            outstanding;
	int unsigned            mismatches;
	int unsigned            cycle_count = 0;
	int                     burst_left;
	int                     hold_requests = 0;
	int                     holds_done = 0;
	int                     rx_style = 0;
	int                     rx_span = 0;
	int                     rx_phase = 0;
	int                     cur_min;
	int                     cur_levels;
	int                     walk = 0;

	mlrd_in_if  sample_ch ();
	mlrd_out_if run_ch ();

	multi_level_run_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_ch),
		.runs      (run_ch)
	);

	multi_level_run_detector_checker run_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_ch   (sample_ch),
		.run_ch      (run_ch),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("multi_level_run_detector_test NOT OK");
			$finish;
		end
	end

	// receiver: changing stall styles, plus long hold-offs on request
	always begin
		@(posedge clk);
		if (hold_requests != holds_done) begin
			holds_done++;
			run_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else begin
			if (rx_span == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_span = $urandom_range(16, 96);
			end
			rx_span--;
			rx_phase++;
			case (rx_style)
				0: run_ch.ready <= 1'b1;
				1: run_ch.ready <= 1'($urandom_range(0, 1));
				2: run_ch.ready <= ($urandom_range(0, 3) == 0);
				default: run_ch.ready <= ((rx_phase % 5) < 2);
			endcase
		end
	end

	// offers one item, waits for it to be taken, then maybe idles between bursts
	task automatic offer(input logic signed [SAMPLE_W-1:0] value, input logic last);
		int gap;
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value;
		sample_ch.last_sample <= last;
		do @(posedge clk); while (!sample_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and wait until every expected report is out
	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// unused upper data bits are filled with noise
	task automatic configure(input int lo, input int unsigned levels, input logic valley);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_LEVEL;
		cfg_data <= CFG_DATA_W'(lo);
		@(posedge clk);
		cfg_index <= CFG_LEVEL_COUNT;
		cfg_data <= {11'($urandom), 5'(levels)};
		@(posedge clk);
		cfg_index <= CFG_VALLEY_MODE;
		cfg_data <= {15'($urandom), valley};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_min = lo;
		cur_levels = (levels == 0) ? 1 : (levels > 16) ? 16 : int'(levels);
	endtask

	// mostly a random walk across the threshold band, so runs open and close
	task automatic random_items(input int unsigned count);
		int unsigned kind;
		int          lo_edge;
		int          hi_edge;
		int          value;
		lo_edge = cur_min * 256 - 600;
		hi_edge = (cur_min + cur_levels) * 256 + 600;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				value = $urandom;
			end else if (kind < 12) begin
				value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			end else if (kind < 22) begin
				value = (cur_min + int'($urandom_range(0, cur_levels))) * 256
					+ int'($urandom_range(0, 2)) - 1;
			end else begin
				walk = walk + int'($urandom_range(0, 800)) - 400;
				if (walk < lo_edge)
					walk = lo_edge;
				if (walk > hi_edge)
					walk = hi_edge;
				value = walk;
			end
			offer(value, $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MIN_LEVEL;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		sample_ch.last_sample <= 1'b0;
		cur_min = 0;
		cur_levels = 16;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 16 peak levels from zero
		offer(0, 1'b0);
		offer(16 * 256 - 1, 1'b0);
		offer(5 * 256, 1'b0);
		offer(5 * 256 - 1, 1'b0);
		offer(32'sh7FFFFFFF, 1'b1);
		offer(32'sh80000000, 1'b0);
		offer(32'sh7FFFFFFF, 1'b0);
		offer(32'sh80000000, 1'b0);
		offer(-1, 1'b1);
		random_items(40);

		// zero count means one level; lowest threshold in valley mode
		settle();
		configure(-32768, 0, 1'b1);
		offer(-32768 * 256, 1'b0);
		offer(-32768 * 256 + 1, 1'b0);
		offer(32'sh80000000, 1'b0);
		offer(32'sh80000000, 1'b1);
		random_items(30);

		// count above the maximum saturates; highest thresholds
		settle();
		configure(32767, 31, 1'b0);
		offer(32'sh7FFFFFFF, 1'b0);
		offer(32767 * 256 + 8 * 256, 1'b0);
		random_items(30);

		settle();
		configure(-5, 1, 1'b0);
		random_items(30);

		settle();
		configure(100, 17, 1'b1);
		random_items(30);

		// runs may still be open across this change
		settle();
		configure(-200, 7, 1'b1);
		random_items(30);

		// long output hold-off while samples keep coming
		settle();
		configure(3, 16, 1'b0);
		hold_requests++;
		random_items(50);

		// levels that become inactive drop their open runs silently
		settle();
		configure(0, 16, 1'b0);
		offer(32'sh7FFFFFFF, 1'b0);
		settle();
		configure(0, 8, 1'b0);
		offer(32'sh80000000, 1'b0);
		random_items(40);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("multi_level_run_detector_test OK");
		end else begin
			$display("multi_level_run_detector_test NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mlrd_pkg.sv
hdl/mlrd_if.sv
hdl/mlrd_cell.sv
hdl/multi_level_run_detector.sv
tb/multi_level_run_detector_checker.sv
tb/multi_level_run_detector_test.sv
